/* rtl/core/bpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg: bounce path predictor shared definitions
// word formats, register indexes, reset values, sequencer codes
// ----------------------------------------------------------------------------
package bpp_pkg;

	// coordinate format, signed q3.12 metres
	localparam int COORD_WIDTH = 16;
	// per-frame step keeps full precision of the difference
	localparam int DELTA_WIDTH = COORD_WIDTH + 1;
	// multiplier operand, wide enough for a coordinate and for the radius
	localparam int MUL_WIDTH = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
	// shared unit width, holds a square sum and every mirror term
	localparam int ALU_WIDTH = 2 * MUL_WIDTH + 1;

	localparam int CFG_WIDTH = 15;
	localparam int STEP_WIDTH = 7;
	localparam int INDEX_WIDTH = 2;

	localparam logic [STEP_WIDTH-1:0] HORIZON_CAP = STEP_WIDTH'(64);

	localparam logic [CFG_WIDTH-1:0] HALF_WIDTH_RST = CFG_WIDTH'(1024);
	localparam logic [CFG_WIDTH-1:0] ARM_RADIUS_RST = CFG_WIDTH'(819);
	localparam logic [STEP_WIDTH-1:0] MAX_STEPS_RST = STEP_WIDTH'(13);

	typedef enum logic [INDEX_WIDTH-1:0] {
		REG_HALF_WIDTH = 2'd0,
		REG_ARM_RADIUS = 2'd1,
		REG_MAX_STEPS  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] first_x;
		logic signed [COORD_WIDTH-1:0] first_y;
		logic signed [COORD_WIDTH-1:0] second_x;
		logic signed [COORD_WIDTH-1:0] second_y;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pred_x;
		logic signed [COORD_WIDTH-1:0] pred_y;
		logic [STEP_WIDTH-1:0]         step_index;
		logic                          in_reach;
		logic                          last;
	} out_word_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_SQR
	} alu_op_t;

	typedef enum logic [2:0] {
		OPA_X,
		OPA_Y,
		OPA_R,
		OPA_R2,
		OPA_T,
		OPA_HW2,
		OPA_NHW2
	} opa_sel_t;

	typedef enum logic [2:0] {
		OPB_ZERO,
		OPB_DX,
		OPB_DY,
		OPB_X1,
		OPB_Y1,
		OPB_X,
		OPB_T,
		OPB_U
	} opb_sel_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_DX,
		DST_DY,
		DST_R2,
		DST_X,
		DST_Y,
		DST_T,
		DST_U
	} dst_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DX,
		ST_DY,
		ST_R2,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_CHECK,
		ST_ADD_X,
		ST_ADD_Y,
		ST_WALL_HI,
		ST_WALL_LO
	} seq_state_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic is_start;
		logic at_limit;
		logic reach;
		logic x_gt_hw;
		logic x_lt_nhw;
	} seq_status_t;

	typedef struct packed {
		logic     in_ready;
		logic     load;
		alu_op_t  op;
		opa_sel_t a_sel;
		opb_sel_t b_sel;
		dst_sel_t dst;
		logic     neg_dx;
		logic     n_inc;
		logic     emit;
		logic     emit_last;
	} seq_ctrl_t;

endpackage

/* rtl/core/bpp_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_alu: shared arithmetic unit
// add, subtract or square on signed operands, one operation per cycle
// ----------------------------------------------------------------------------
module bpp_alu (
	input  bpp_pkg::alu_op_t                        op,
	input  logic signed [bpp_pkg::ALU_WIDTH-1:0]    a,
	input  logic signed [bpp_pkg::ALU_WIDTH-1:0]    b,
	output logic signed [bpp_pkg::ALU_WIDTH-1:0]    y
);

	localparam int MW = bpp_pkg::MUL_WIDTH;
	localparam int UW = bpp_pkg::ALU_WIDTH;

	logic signed [MW-1:0]   m;
	logic signed [2*MW-1:0] prod;

	// squaring uses the low part, operands are always narrow enough
	assign m    = a[MW-1:0];
	assign prod = m * m;

	always_comb begin
		case (op)
			bpp_pkg::ALU_ADD: y = a + b;
			bpp_pkg::ALU_SUB: y = a - b;
			bpp_pkg::ALU_SQR: y = {{(UW-2*MW){prod[2*MW-1]}}, prod};
			default:          y = a + b;
		endcase
	end

endmodule

/* rtl/core/bpp_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_seq: prediction sequencer
// walks the shared unit through the delta, reach test and frame steps
// ----------------------------------------------------------------------------
module bpp_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpp_pkg::seq_status_t  status,
	output bpp_pkg::seq_ctrl_t    ctrl
);

	bpp_pkg::seq_state_t state_q;
	bpp_pkg::seq_state_t state_nxt;
	logic                done;

	// stop on reach or at the horizon
	assign done = status.reach || status.at_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bpp_pkg::ST_IDLE: begin
				if (status.in_valid) state_nxt = bpp_pkg::ST_DX;
			end
			bpp_pkg::ST_DX:      state_nxt = bpp_pkg::ST_DY;
			bpp_pkg::ST_DY:      state_nxt = bpp_pkg::ST_R2;
			bpp_pkg::ST_R2:      state_nxt = bpp_pkg::ST_SQX;
			bpp_pkg::ST_SQX:     state_nxt = bpp_pkg::ST_SQY;
			bpp_pkg::ST_SQY:     state_nxt = bpp_pkg::ST_SUM;
			bpp_pkg::ST_SUM:     state_nxt = bpp_pkg::ST_CHECK;
			bpp_pkg::ST_CHECK: begin
				if (status.out_free) begin
					state_nxt = done ? bpp_pkg::ST_IDLE : bpp_pkg::ST_ADD_X;
				end
			end
			bpp_pkg::ST_ADD_X:   state_nxt = bpp_pkg::ST_ADD_Y;
			bpp_pkg::ST_ADD_Y:   state_nxt = bpp_pkg::ST_WALL_HI;
			bpp_pkg::ST_WALL_HI: state_nxt = bpp_pkg::ST_WALL_LO;
			bpp_pkg::ST_WALL_LO: state_nxt = bpp_pkg::ST_SQX;
			default:             state_nxt = bpp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.in_ready  = 1'b0;
		ctrl.load      = 1'b0;
		ctrl.op        = bpp_pkg::ALU_ADD;
		ctrl.a_sel     = bpp_pkg::OPA_X;
		ctrl.b_sel     = bpp_pkg::OPB_ZERO;
		ctrl.dst       = bpp_pkg::DST_NONE;
		ctrl.neg_dx    = 1'b0;
		ctrl.n_inc     = 1'b0;
		ctrl.emit      = 1'b0;
		ctrl.emit_last = 1'b0;
		case (state_q)
			bpp_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.load     = status.in_valid;
			end
			bpp_pkg::ST_DX: begin
				ctrl.op    = bpp_pkg::ALU_SUB;
				ctrl.a_sel = bpp_pkg::OPA_X;
				ctrl.b_sel = bpp_pkg::OPB_X1;
				ctrl.dst   = bpp_pkg::DST_DX;
			end
			bpp_pkg::ST_DY: begin
				ctrl.op    = bpp_pkg::ALU_SUB;
				ctrl.a_sel = bpp_pkg::OPA_Y;
				ctrl.b_sel = bpp_pkg::OPB_Y1;
				ctrl.dst   = bpp_pkg::DST_DY;
			end
			bpp_pkg::ST_R2: begin
				ctrl.op    = bpp_pkg::ALU_SQR;
				ctrl.a_sel = bpp_pkg::OPA_R;
				ctrl.dst   = bpp_pkg::DST_R2;
			end
			bpp_pkg::ST_SQX: begin
				ctrl.op    = bpp_pkg::ALU_SQR;
				ctrl.a_sel = bpp_pkg::OPA_X;
				ctrl.dst   = bpp_pkg::DST_T;
			end
			bpp_pkg::ST_SQY: begin
				ctrl.op    = bpp_pkg::ALU_SQR;
				ctrl.a_sel = bpp_pkg::OPA_Y;
				ctrl.dst   = bpp_pkg::DST_U;
			end
			bpp_pkg::ST_SUM: begin
				ctrl.op    = bpp_pkg::ALU_ADD;
				ctrl.a_sel = bpp_pkg::OPA_T;
				ctrl.b_sel = bpp_pkg::OPB_U;
				ctrl.dst   = bpp_pkg::DST_T;
			end
			bpp_pkg::ST_CHECK: begin
				// r squared minus distance squared, sign gives reach
				ctrl.op    = bpp_pkg::ALU_SUB;
				ctrl.a_sel = bpp_pkg::OPA_R2;
				ctrl.b_sel = bpp_pkg::OPB_T;
				if (status.out_free) begin
					ctrl.emit      = status.reach || !status.is_start;
					ctrl.emit_last = done;
					ctrl.n_inc     = !done;
				end
			end
			bpp_pkg::ST_ADD_X: begin
				ctrl.op    = bpp_pkg::ALU_ADD;
				ctrl.a_sel = bpp_pkg::OPA_X;
				ctrl.b_sel = bpp_pkg::OPB_DX;
				ctrl.dst   = bpp_pkg::DST_X;
			end
			bpp_pkg::ST_ADD_Y: begin
				ctrl.op    = bpp_pkg::ALU_ADD;
				ctrl.a_sel = bpp_pkg::OPA_Y;
				ctrl.b_sel = bpp_pkg::OPB_DY;
				ctrl.dst   = bpp_pkg::DST_Y;
			end
			bpp_pkg::ST_WALL_HI: begin
				ctrl.op     = bpp_pkg::ALU_SUB;
				ctrl.a_sel  = bpp_pkg::OPA_HW2;
				ctrl.b_sel  = bpp_pkg::OPB_X;
				ctrl.dst    = status.x_gt_hw ? bpp_pkg::DST_X : bpp_pkg::DST_NONE;
				ctrl.neg_dx = status.x_gt_hw;
			end
			bpp_pkg::ST_WALL_LO: begin
				ctrl.op     = bpp_pkg::ALU_SUB;
				ctrl.a_sel  = bpp_pkg::OPA_NHW2;
				ctrl.b_sel  = bpp_pkg::OPB_X;
				ctrl.dst    = status.x_lt_nhw ? bpp_pkg::DST_X : bpp_pkg::DST_NONE;
				ctrl.neg_dx = status.x_lt_nhw;
			end
			default: begin
				ctrl.in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/bounce_path_predictor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounce_path_predictor_top: ball bounce path predictor
// steps a ball forward from two frame positions, mirrors at the side walls
// ----------------------------------------------------------------------------
// A word carries two successive ball positions in signed q3.12 metres. The
// per-frame step is their difference; the ball is advanced from the later
// position one frame at a time, at most max_steps frames (0 acts as 1, above
// 64 acts as 64), until it lies within arm_radius of the origin. Every frame
// step gives one output word; the final word has last set and in_reach tells
// whether the ball ended within reach. A ball that starts within reach gives
// one word with the start point and step_index 0. All work runs through one
// shared add/subtract/square unit under a sequencer, one operation a cycle
// while the compare step is not held waiting for a free output register:
// after the input word is taken, it sets up the step and tests the start
// point, then each frame step runs two adds, two wall tests, two squares,
// one sum and one compare. Every compare waits until the output register
// is free or out_ready is high. The next input word is taken only after the
// last word of an item is registered and the sequencer is back in idle.
// in_ready is high only between items; the output word sits in its own
// register, so the next input word can be taken while the last result
// still waits. Registers are to be written only while idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module bounce_path_predictor_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [bpp_pkg::INDEX_WIDTH-1:0]        cfg_index,
	input  logic [bpp_pkg::CFG_WIDTH-1:0]          cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  bpp_pkg::in_word_t                      in_word,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output bpp_pkg::out_word_t                     out_word
);

	localparam int W  = bpp_pkg::COORD_WIDTH;
	localparam int DW = bpp_pkg::DELTA_WIDTH;
	localparam int UW = bpp_pkg::ALU_WIDTH;
	localparam int CW = bpp_pkg::CFG_WIDTH;
	localparam int SW = bpp_pkg::STEP_WIDTH;

	// saturation bounds of a coordinate, at unit width
	localparam logic signed [UW-1:0] CMAX = {{(UW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [UW-1:0] CMIN = ~CMAX;

	// configuration registers
	logic [CW-1:0] half_width_q;
	logic [CW-1:0] arm_radius_q;
	logic [SW-1:0] max_steps_q;

	// working registers of one item
	logic signed [W-1:0]  x1_q;
	logic signed [W-1:0]  y1_q;
	logic signed [W-1:0]  x_q;
	logic signed [W-1:0]  y_q;
	logic signed [DW-1:0] dx_q;
	logic signed [DW-1:0] dy_q;
	logic signed [UW-1:0] r2_q;
	logic signed [UW-1:0] t_q;
	logic signed [UW-1:0] u_q;
	logic [SW-1:0]        n_q;
	logic [SW-1:0]        limit_q;
	logic [SW-1:0]        limit_nxt;

	// output register
	logic                 out_valid_q;
	bpp_pkg::out_word_t   out_word_q;

	// shared unit and sequencer
	logic signed [UW-1:0] alu_a;
	logic signed [UW-1:0] alu_b;
	logic signed [UW-1:0] alu_y;
	logic signed [UW-1:0] x_ext;
	logic signed [UW-1:0] hw_ext;
	logic signed [W-1:0]  alu_sat;
	bpp_pkg::seq_status_t status;
	bpp_pkg::seq_ctrl_t   ctrl;

	function automatic logic signed [W-1:0] sat_coord(input logic signed [UW-1:0] v);
		logic signed [W-1:0] r;
		if (v > CMAX) begin
			r = CMAX[W-1:0];
		end else if (v < CMIN) begin
			r = CMIN[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// configuration port, unknown indexes are dropped
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= bpp_pkg::HALF_WIDTH_RST;
			arm_radius_q <= bpp_pkg::ARM_RADIUS_RST;
			max_steps_q  <= bpp_pkg::MAX_STEPS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bpp_pkg::REG_HALF_WIDTH: half_width_q <= cfg_data;
				bpp_pkg::REG_ARM_RADIUS: arm_radius_q <= cfg_data;
				bpp_pkg::REG_MAX_STEPS:  max_steps_q  <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// horizon clamped to 1..64
	always_comb begin
		if (max_steps_q == '0) begin
			limit_nxt = SW'(1);
		end else if (max_steps_q > bpp_pkg::HORIZON_CAP) begin
			limit_nxt = bpp_pkg::HORIZON_CAP;
		end else begin
			limit_nxt = max_steps_q;
		end
	end

	// ---------------------------------------------------------------------
	// operand selection
	// ---------------------------------------------------------------------
	assign x_ext  = {{(UW-W){x_q[W-1]}}, x_q};
	assign hw_ext = {{(UW-CW){1'b0}}, half_width_q};

	always_comb begin
		case (ctrl.a_sel)
			bpp_pkg::OPA_X:    alu_a = x_ext;
			bpp_pkg::OPA_Y:    alu_a = {{(UW-W){y_q[W-1]}}, y_q};
			bpp_pkg::OPA_R:    alu_a = {{(UW-CW){1'b0}}, arm_radius_q};
			bpp_pkg::OPA_R2:   alu_a = r2_q;
			bpp_pkg::OPA_T:    alu_a = t_q;
			bpp_pkg::OPA_HW2:  alu_a = hw_ext <<< 1;
			bpp_pkg::OPA_NHW2: alu_a = -(hw_ext <<< 1);
			default:           alu_a = x_ext;
		endcase
	end

	always_comb begin
		case (ctrl.b_sel)
			bpp_pkg::OPB_ZERO: alu_b = '0;
			bpp_pkg::OPB_DX:   alu_b = {{(UW-DW){dx_q[DW-1]}}, dx_q};
			bpp_pkg::OPB_DY:   alu_b = {{(UW-DW){dy_q[DW-1]}}, dy_q};
			bpp_pkg::OPB_X1:   alu_b = {{(UW-W){x1_q[W-1]}}, x1_q};
			bpp_pkg::OPB_Y1:   alu_b = {{(UW-W){y1_q[W-1]}}, y1_q};
			bpp_pkg::OPB_X:    alu_b = x_ext;
			bpp_pkg::OPB_T:    alu_b = t_q;
			bpp_pkg::OPB_U:    alu_b = u_q;
			default:           alu_b = '0;
		endcase
	end

	bpp_alu u_alu (
		.op (ctrl.op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	assign alu_sat = sat_coord(alu_y);

	// ---------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------
	assign status.in_valid = in_valid;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.is_start = (n_q == '0);
	assign status.at_limit = (n_q == limit_q);
	// valid in the compare cycle: r squared minus distance squared not negative
	assign status.reach    = !alu_y[UW-1];
	// wall tests on the current x
	assign status.x_gt_hw  = (x_ext > hw_ext);
	assign status.x_lt_nhw = (x_ext < -hw_ext);

	bpp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_ready = ctrl.in_ready;

	// ---------------------------------------------------------------------
	// working registers, written back from the shared unit
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x1_q    <= in_word.first_x;
			y1_q    <= in_word.first_y;
			x_q     <= in_word.second_x;
			y_q     <= in_word.second_y;
			limit_q <= limit_nxt;
		end else begin
			case (ctrl.dst)
				bpp_pkg::DST_DX: dx_q <= alu_y[DW-1:0];
				bpp_pkg::DST_DY: dy_q <= alu_y[DW-1:0];
				bpp_pkg::DST_R2: r2_q <= alu_y;
				bpp_pkg::DST_X:  x_q  <= alu_sat;
				bpp_pkg::DST_Y:  y_q  <= alu_sat;
				bpp_pkg::DST_T:  t_q  <= alu_y;
				bpp_pkg::DST_U:  u_q  <= alu_y;
				default: ;
			endcase
			// a wall hit flips the x step, kept at full precision
			if (ctrl.neg_dx) begin
				dx_q <= -dx_q;
			end
		end
	end

	// frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (ctrl.load) begin
			n_q <= '0;
		end else if (ctrl.n_inc) begin
			n_q <= n_q + SW'(1);
		end
	end

	// ---------------------------------------------------------------------
	// output word register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_word_q.pred_x     <= x_q;
			out_word_q.pred_y     <= y_q;
			out_word_q.step_index <= n_q;
			out_word_q.in_reach   <= status.reach;
			out_word_q.last       <= ctrl.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	// busy right after taking a word
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> !in_ready)
		else $error("input taken again while an item is in work");

	// never step past the horizon
	a_step_in_horizon: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.n_inc |-> (n_q < limit_q))
		else $error("frame step beyond the horizon");

	// an emitted word never carries a frame count above the horizon
	a_emit_in_horizon: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (n_q <= limit_q))
		else $error("output word beyond the horizon");

	// reach is only reported on the final word
	a_reach_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.in_reach) |-> out_word.last)
		else $error("in_reach set on a word that is not last");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bounce path predictor testbench
// feeds pairs of ball positions through the valid/ready input and predicts
// every path point with a behavioral model of the stepping, wall mirroring,
// saturation and reach test; each output word is checked in order, field by
// field, against the oldest prediction, across several register settings
// ----------------------------------------------------------------------------
module tb;

	localparam int COORD_W = bpp_pkg::COORD_WIDTH;
	localparam int STEP_W  = bpp_pkg::STEP_WIDTH;
	localparam int CFG_W   = bpp_pkg::CFG_WIDTH;
	localparam int IDX_W   = bpp_pkg::INDEX_WIDTH;

	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int DRAIN_CYCLES = 600;
	localparam int RESET_CYCLES = 8;
	// index past the register list, the block must ignore writes to it
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;

	typedef enum logic [1:0] {
		TRACK_AIMED,
		TRACK_BOUNCE,
		TRACK_HOME,
		TRACK_NOISE
	} track_kind_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_CHOPPY,
		RX_SLUGGISH
	} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	bpp_pkg::in_word_t      in_word;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	bpp_pkg::out_word_t     out_word;

	// own copy of the register file, follows every write
	logic [CFG_W-1:0]  wall_cfg    = bpp_pkg::HALF_WIDTH_RST;
	logic [CFG_W-1:0]  reach_cfg   = bpp_pkg::ARM_RADIUS_RST;
	logic [STEP_W-1:0] horizon_cfg = bpp_pkg::MAX_STEPS_RST;

	// predicted path points, oldest first
	bpp_pkg::out_word_t path_points[$];
	bpp_pkg::out_word_t due_point;
	int        error_count = 0;
	int        cycle_count = 0;
	int        burst_left  = 0;

	// receiver stall pattern state
	rx_mode_t  rx_mode   = RX_OPEN;
	int        mode_left = 100;
	int        hold_left = 0;

	bounce_path_predictor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always #10 clk = ~clk;

	// run limit, sized for every item stepping the full horizon under long stalls
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// path model
	// ------------------------------------------------------------------------

	function automatic longint clamp_coord(longint v);
		if (v > COORD_HI)
			return COORD_HI;
		if (v < COORD_LO)
			return COORD_LO;
		return v;
	endfunction

	// inclusive reach test, exact square compare
	function automatic bit near_arm(longint x, longint y);
		longint r;
		r = longint'(reach_cfg);
		return x * x + y * y <= r * r;
	endfunction

	// appends one predicted point behind the others
	function automatic void queue_point(bpp_pkg::out_word_t pt);
		path_points = {path_points, pt};
	endfunction

	// works out every point one word produces and queues them
	function automatic void forecast_path(bpp_pkg::in_word_t w);
		longint    x;
		longint    y;
		longint    dx;
		longint    dy;
		longint    hw;
		int        horizon;
		int        n;
		bit        reach;
		bit        done;
		bpp_pkg::out_word_t pt;
		x  = longint'($signed(w.second_x));
		y  = longint'($signed(w.second_y));
		dx = x - longint'($signed(w.first_x));
		dy = y - longint'($signed(w.first_y));
		hw = longint'(wall_cfg);
		horizon = int'(horizon_cfg);
		// a horizon of zero still steps once, anything past the cap is capped
		if (horizon < 1)
			horizon = 1;
		if (horizon > int'(bpp_pkg::HORIZON_CAP))
			horizon = int'(bpp_pkg::HORIZON_CAP);
		// ball already within reach: start point only
		if (near_arm(x, y)) begin
			pt.pred_x     = COORD_W'(x);
			pt.pred_y     = COORD_W'(y);
			pt.step_index = '0;
			pt.in_reach   = 1'b1;
			pt.last       = 1'b1;
			queue_point(pt);
			return;
		end
		for (n = 1; n <= horizon; n++) begin
			x = clamp_coord(x + dx);
			y = clamp_coord(y + dy);
			// high wall first; a fast ball can then land past the low wall too
			if (x > hw) begin
				dx = -dx;
				x  = clamp_coord(2 * hw - x);
			end
			if (x < -hw) begin
				dx = -dx;
				x  = clamp_coord(-2 * hw - x);
			end
			reach = near_arm(x, y);
			done  = reach || n == horizon;
			pt.pred_x     = COORD_W'(x);
			pt.pred_y     = COORD_W'(y);
			pt.step_index = STEP_W'(n);
			pt.in_reach   = done && reach;
			pt.last       = done;
			queue_point(pt);
			if (done)
				break;
		end
	endfunction

	// ------------------------------------------------------------------------
	// output check
	// ------------------------------------------------------------------------

	function automatic void match_field(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// every accepted output word is held against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (path_points.size() == 0) begin
				error_count++;
				$display("%0t: unexpected word, expected none, actual x %0d y %0d step %0d",
					$time, out_word.pred_x, out_word.pred_y, out_word.step_index);
			end else begin
				due_point = path_points.pop_front();
				match_field("pred_x", 64'($signed(due_point.pred_x)),
					64'($signed(out_word.pred_x)));
				match_field("pred_y", 64'($signed(due_point.pred_y)),
					64'($signed(out_word.pred_y)));
				match_field("step_index", 64'(due_point.step_index),
					64'(out_word.step_index));
				match_field("in_reach", 64'(due_point.in_reach), 64'(out_word.in_reach));
				match_field("last", 64'(due_point.last), 64'(out_word.last));
			end
		end
	end

	// receiver: open, choppy or sluggish with long holds, mode changes now and then
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_CHOPPY: out_ready <= ($urandom_range(3) != 0);
				default: begin
					out_ready <= 1'b1;
					if ($urandom_range(9) == 0)
						hold_left <= $urandom_range(24, 1);
				end
			endcase
		end
		if (mode_left == 0) begin
			rx_mode   <= rx_mode_t'($urandom_range(2));
			mode_left <= $urandom_range(400, 50);
		end else
			mode_left <= mode_left - 1;
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic longint pick(longint lo, longint hi);
		if (hi <= lo)
			return lo;
		return lo + longint'($urandom_range(32'(hi - lo)));
	endfunction

	function automatic bpp_pkg::in_word_t ball_frames(longint x1, longint y1, longint x2,
		longint y2);
		bpp_pkg::in_word_t w;
		w.first_x  = COORD_W'(clamp_coord(x1));
		w.first_y  = COORD_W'(clamp_coord(y1));
		w.second_x = COORD_W'(clamp_coord(x2));
		w.second_y = COORD_W'(clamp_coord(y2));
		return w;
	endfunction

	// random pair of frames of the given flavor, scaled to the current registers
	function automatic bpp_pkg::in_word_t make_track(track_kind_t kind);
		longint r;
		longint hw;
		longint tx;
		longint ty;
		longint vx;
		longint vy;
		longint k;
		r  = longint'(reach_cfg);
		hw = longint'(wall_cfg);
		case (kind)
			TRACK_HOME: begin
				// second position inside the reach circle
				tx = pick(-(r * 7 / 10), r * 7 / 10);
				ty = pick(-(r * 7 / 10), r * 7 / 10);
				vx = pick(-3000, 3000);
				vy = pick(-3000, 3000);
				return ball_frames(tx - vx, ty - vy, tx, ty);
			end
			TRACK_AIMED: begin
				// straight line that would pass near the arm within a few frames
				tx = pick(-(r * 7 / 10), r * 7 / 10);
				ty = pick(-(r * 7 / 10), r * 7 / 10);
				vx = pick(-1500, 1500);
				vy = pick(-1500, 1500);
				k  = pick(1, 10);
				return ball_frames(tx - (k + 1) * vx, ty - (k + 1) * vy, tx - k * vx,
					ty - k * vy);
			end
			TRACK_BOUNCE: begin
				// hard sideways shot between the walls, drifting toward the arm in y
				tx = pick(-hw, hw);
				vx = pick(hw / 8 + 1, 2 * hw + 200);
				if ($urandom_range(1))
					vx = -vx;
				vy = pick(-600, 600);
				k  = pick(1, 10);
				ty = -k * vy + pick(-(r / 2), r / 2);
				return ball_frames(tx - vx, ty - vy, tx, ty);
			end
			default: return bpp_pkg::in_word_t'({$urandom, $urandom});
		endcase
	endfunction

	// one word through the input handshake; valid stays up for a following word
	task automatic send_pair(input bpp_pkg::in_word_t w);
		@(negedge clk);
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		forecast_path(w);
	endtask

	task automatic pause_input(input int gap);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap) @(negedge clk);
	endtask

	// sender works in bursts; gaps land on any phase of the block's stepping
	task automatic feed_pair(input bpp_pkg::in_word_t w);
		send_pair(w);
		if (burst_left > 0)
			burst_left--;
		else begin
			pause_input($urandom_range(40));
			burst_left = ($urandom_range(7) == 0) ? 30 : $urandom_range(5);
		end
	endtask

	// returns at a falling edge with no word pending and the block between items
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(negedge clk); while (path_points.size() != 0 || !in_ready);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			bpp_pkg::REG_HALF_WIDTH: wall_cfg = data;
			bpp_pkg::REG_ARM_RADIUS: reach_cfg = data;
			bpp_pkg::REG_MAX_STEPS: horizon_cfg = data[STEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset register values: start in reach, walls, saturation, horizon expiry
	task automatic test_start_and_walls();
		feed_pair(ball_frames(0, 0, 0, 0));
		// exactly on the radius still counts as within reach
		feed_pair(ball_frames(819, 0, 819, 0));
		// one step inside from just outside
		feed_pair(ball_frames(900, 0, 820, 0));
		// at rest far away, runs out of horizon
		feed_pair(ball_frames(0, 8000, 0, 8000));
		// high wall then low wall on separate steps
		feed_pair(ball_frames(700, 4300, 900, 4000));
		feed_pair(ball_frames(-700, -4300, -900, -4000));
		// one step that crosses both walls
		feed_pair(ball_frames(-4000, 12000, 1000, 12000));
		// field extremes, coordinate saturation in both directions
		feed_pair(ball_frames(COORD_LO, COORD_LO, COORD_HI, COORD_HI));
		feed_pair(ball_frames(COORD_HI, COORD_HI, COORD_LO, COORD_LO));
		feed_pair(ball_frames(COORD_HI, COORD_LO, COORD_LO, COORD_HI));
	endtask

	// register extremes, horizon out of range, spare index
	task automatic test_register_extremes();
		write_reg(bpp_pkg::REG_MAX_STEPS, 15'd0);
		feed_pair(ball_frames(100, -20000, 0, -20000));
		// upper data bits fall away: 65, capped to the full horizon
		write_reg(bpp_pkg::REG_MAX_STEPS, 15'h7F41);
		feed_pair(ball_frames(0, 20000, 0, 20000));
		write_reg(bpp_pkg::REG_MAX_STEPS, 15'd127);
		feed_pair(ball_frames(0, -20000, 700, -19900));
		write_reg(bpp_pkg::REG_MAX_STEPS, 15'd1);
		write_reg(REG_SPARE, 15'h7FFF);
		feed_pair(ball_frames(0, 5000, 0, 4000));
		// zero wall and zero radius: only the origin is in reach
		write_reg(bpp_pkg::REG_HALF_WIDTH, 15'd0);
		write_reg(bpp_pkg::REG_ARM_RADIUS, 15'd0);
		write_reg(bpp_pkg::REG_MAX_STEPS, 15'd5);
		feed_pair(ball_frames(0, 0, 0, 0));
		feed_pair(ball_frames(-31000, 100, -32000, 100));
		feed_pair(ball_frames(200, -200, 100, -100));
		write_reg(bpp_pkg::REG_HALF_WIDTH, 15'h7FFF);
		write_reg(bpp_pkg::REG_ARM_RADIUS, 15'h7FFF);
		write_reg(bpp_pkg::REG_MAX_STEPS, 15'd3);
		feed_pair(ball_frames(COORD_HI, COORD_HI, COORD_HI, COORD_HI));
		feed_pair(ball_frames(32000, 32000, 30000, 30000));
	endtask

	// phases of random tracks under a spread of register settings
	task automatic test_random_tracks();
		int unsigned wall_plan[10]    = '{1024, 4096, 300, 32767, 0, 20000, 8192, 0, 0, 600};
		int unsigned radius_plan[10]  = '{819, 2048, 1500, 32767, 0, 400, 3000, 0, 0, 1};
		int unsigned horizon_plan[10] = '{13, 8, 4, 1, 2, 64, 16, 0, 0, 6};
		int          phase;
		int          i;
		int          roll;
		track_kind_t kind;
		for (phase = 0; phase < 10; phase++) begin
			// two phases draw their own settings
			if (phase == 7 || phase == 8) begin
				wall_plan[phase]    = $urandom_range(32767);
				radius_plan[phase]  = $urandom_range(6000);
				horizon_plan[phase] = $urandom_range(20, 1);
			end
			write_reg(bpp_pkg::REG_HALF_WIDTH, CFG_W'(wall_plan[phase]));
			write_reg(bpp_pkg::REG_ARM_RADIUS, CFG_W'(radius_plan[phase]));
			write_reg(bpp_pkg::REG_MAX_STEPS, CFG_W'(horizon_plan[phase]));
			// the full horizon is slow, fewer words there
			for (i = 0; i < ((horizon_plan[phase] == 64) ? 20 : 40); i++) begin
				roll = $urandom_range(99);
				if (roll < 50)
					kind = TRACK_AIMED;
				else if (roll < 70)
					kind = TRACK_BOUNCE;
				else if (roll < 85)
					kind = TRACK_HOME;
				else
					kind = TRACK_NOISE;
				feed_pair(make_track(kind));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = bpp_pkg::REG_HALF_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_word   = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_start_and_walls();
		test_register_extremes();
		test_random_tracks();

		// all words taken: wait for the remaining points, then for strays
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
rtl/core/bpp_pkg.sv
rtl/core/bpp_alu.sv
rtl/core/bpp_seq.sv
rtl/core/bounce_path_predictor_top.sv
sim/tb.sv
